// File: src/tsad_pkg.sv
// Shared constants, register map and the power-of-two table builder
// for the two-step devolatilization pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsad_pkg;

    // Build options
    localparam bit SINGLE_SPECIES = 1'b0;
    localparam int EXP_TABLE_BITS = 8;

    // Divider: 36-bit dividend, 4 quotient bits per stage
    localparam int DIVIDEND_BITS = 36;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STAGES    = DIVIDEND_BITS / DIV_BITS;

    // log2(e) in Q16 and the per-reaction clamp
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [31:0] DM_MAX    = 32'hFFFF_FFFF;

    // Register map
    localparam logic [2:0] REG_RATE_A  = 3'd0;
    localparam logic [2:0] REG_RATE_B  = 3'd1;
    localparam logic [2:0] REG_ACT_A   = 3'd2;
    localparam logic [2:0] REG_ACT_B   = 3'd3;
    localparam logic [2:0] REG_ONSET_A = 3'd4;
    localparam logic [2:0] REG_ONSET_B = 3'd5;
    localparam logic [2:0] REG_YIELD_A = 3'd6;
    localparam logic [2:0] REG_YIELD_B = 3'd7;

    // Integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bit_v)
            begin
                n   = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // C[k] = floor(sqrt(C[k-1] * 2^32)), C[0] = 2^31: 2^-(2^-k) in Q0.32
    function automatic logic [31:0] pow_tab(input int k);
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int j = 1; j <= 16; j++)
        begin
            if (j <= k)
            begin
                c = isqrt64(c << 32);
            end
        end
        return c[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/two_step_arrhenius_devolatilization.sv
// Two competing rate devolatilization pipeline, top level.
// Throughput: one beat per cycle while no finished result is held by out_stall;
// the 9-stage restoring divider (4 bits a stage) and one exp table stage per
// fraction bit set the depth.
// Reset: rst_n asynchronous, clears valid bits and configuration registers.
// Depends on tsad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module two_step_arrhenius_devolatilization
(
    input  wire                clk,
    input  wire                rst_n,
    // configuration write channel
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [2:0]         cfg_index,
    input  wire  [47:0]        cfg_data,
    // input channel
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [31:0]        time_step,
    input  wire  [15:0]        particle_temp,
    input  wire  [31:0]        particle_mass,
    input  wire  [15:0]        raw_fraction,
    input  wire  [15:0]        solid_fraction,
    // output channel
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [33:0] gas_delta_first,
    output logic signed [32:0] gas_delta_second,
    output logic signed [33:0] char_delta,
    output logic [32:0]        raw_delta
);

    localparam int DIV_STAGES = tsad_pkg::DIV_STAGES;
    localparam int DIV_BITS   = tsad_pkg::DIV_BITS;
    localparam int EXP_STAGES = tsad_pkg::EXP_TABLE_BITS;

    // Everything one beat carries down the pipe; each stage fills its part
    typedef struct packed {
        logic [31:0]       dt;
        logic [15:0]       t;
        logic              tz;
        logic [47:0]       mr;
        logic [15:0]       solf;
        logic [31:0]       raw;
        logic [1:0]        en;
        logic [1:0][15:0]  rem;
        logic [1:0][35:0]  quo;
        logic [1:0][5:0]   nsh;
        logic [1:0][15:0]  frac;
        logic [1:0]        zero;
        logic [1:0][32:0]  e;
        logic [1:0][63:0]  q;
        logic [1:0][63:0]  pl;
        logic [1:0][63:0]  ph;
        logic [1:0][63:0]  v;
        logic [1:0][63:0]  p00;
        logic [1:0][47:0]  p01;
        logic [1:0][63:0]  p10;
        logic [1:0][47:0]  p11;
        logic [1:0][31:0]  dm;
        logic [1:0][31:0]  g;
    } work_t;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [47:0] rate_a_reg, rate_b_reg;
    logic [15:0] act_a_reg, act_b_reg;
    logic [15:0] onset_a_reg, onset_b_reg;
    logic [15:0] yield_a_reg, yield_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_a_reg  <= '0;
            rate_b_reg  <= '0;
            act_a_reg   <= '0;
            act_b_reg   <= '0;
            onset_a_reg <= '0;
            onset_b_reg <= '0;
            yield_a_reg <= '0;
            yield_b_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsad_pkg::REG_RATE_A:  rate_a_reg  <= cfg_data;
                tsad_pkg::REG_RATE_B:  rate_b_reg  <= cfg_data;
                tsad_pkg::REG_ACT_A:   act_a_reg   <= cfg_data[15:0];
                tsad_pkg::REG_ACT_B:   act_b_reg   <= cfg_data[15:0];
                tsad_pkg::REG_ONSET_A: onset_a_reg <= cfg_data[15:0];
                tsad_pkg::REG_ONSET_B: onset_b_reg <= cfg_data[15:0];
                tsad_pkg::REG_YIELD_A: yield_a_reg <= cfg_data[15:0];
                tsad_pkg::REG_YIELD_B: yield_b_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-reaction views
    logic [1:0][47:0] rate_w;
    logic [1:0][15:0] act_w;
    logic [1:0][15:0] onset_w;
    logic [1:0][15:0] yield_w;

    assign rate_w  = {rate_b_reg, rate_a_reg};
    assign act_w   = {act_b_reg, act_a_reg};
    assign onset_w = {onset_b_reg, onset_a_reg};
    assign yield_w = {yield_b_reg, yield_a_reg};

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves unless a finished beat is held
    logic out_vld_reg;
    logic adv;

    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Input stage: enables, mass times raw fraction
    work_t in_reg, in_next;
    logic  in_vld_reg;

    always_comb
    begin
        in_next      = '0;
        in_next.dt   = time_step;
        in_next.t    = particle_temp;
        in_next.tz   = (particle_temp == 16'd0);
        in_next.mr   = 48'(particle_mass) * 48'(raw_fraction);
        in_next.solf = solid_fraction;
        for (int i = 0; i < 2; i++)
        begin
            in_next.en[i] = (particle_temp >= onset_w[i]);
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider (Ta << 20) / T, DIV_BITS quotient bits a stage
    work_t div_reg [DIV_STAGES];
    work_t div_next [DIV_STAGES];
    work_t div_in [DIV_STAGES];
    logic  div_vld_reg [DIV_STAGES];
    logic  div_vld_in [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_div
            if (j == 0)
            begin : g_first
                assign div_in[j]     = in_reg;
                assign div_vld_in[j] = in_vld_reg;
            end
            else
            begin : g_rest
                assign div_in[j]     = div_reg[j-1];
                assign div_vld_in[j] = div_vld_reg[j-1];
            end

            always_comb
            begin
                logic [63:0] rp;
                logic [35:0] dvd;
                logic [16:0] r17;
                logic [15:0] rem;
                logic [35:0] quo;
                div_next[j] = div_in[j];
                // raw coal mass rides along in the first divider stage
                if (j == 0)
                begin
                    rp              = 64'(div_in[j].mr) * 64'(div_in[j].solf);
                    div_next[j].raw = rp[63:32];
                end
                else
                begin
                    rp = '0;
                end
                for (int i = 0; i < 2; i++)
                begin
                    dvd = {act_w[i], 20'd0};
                    rem = div_in[j].rem[i];
                    quo = div_in[j].quo[i];
                    for (int s = 0; s < DIV_BITS; s++)
                    begin
                        r17 = {rem, dvd[tsad_pkg::DIVIDEND_BITS - 1 - j * DIV_BITS - s]};
                        if (r17 >= {1'b0, div_in[j].t})
                        begin
                            r17 = r17 - {1'b0, div_in[j].t};
                            quo = {quo[34:0], 1'b1};
                        end
                        else
                        begin
                            quo = {quo[34:0], 1'b0};
                        end
                        rem = r17[15:0];
                    end
                    div_next[j].rem[i] = rem;
                    div_next[j].quo[i] = quo;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_vld_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    div_vld_reg[j] <= div_vld_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_reg[j] <= div_next[j];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Base-2 exponent: y = x * log2(e), split into shift and fraction
    work_t y_reg, y_next;
    logic  y_vld_reg;

    always_comb
    begin
        logic [53:0] ysum;
        logic [21:0] n;
        y_next = div_reg[DIV_STAGES-1];
        for (int i = 0; i < 2; i++)
        begin
            ysum = 54'(div_reg[DIV_STAGES-1].quo[i]) * 54'(tsad_pkg::LOG2E_Q16)
                 + 54'd32768;
            n              = ysum[53:32];
            y_next.nsh[i]  = n[5:0];
            y_next.frac[i] = ysum[31:16];
            y_next.zero[i] = div_reg[DIV_STAGES-1].tz || (n >= 22'd33);
            y_next.e[i]    = 33'h1_0000_0000;
        end
    end

    // ------------------------------------------------------------------
    // Fraction bits: one table multiply per stage
    work_t exp_reg [EXP_STAGES];
    work_t exp_next [EXP_STAGES];
    work_t exp_in [EXP_STAGES];
    logic  exp_vld_reg [EXP_STAGES];
    logic  exp_vld_in [EXP_STAGES];

    genvar k;
    generate
        for (k = 0; k < EXP_STAGES; k++)
        begin : g_exp
            localparam logic [31:0] CK = tsad_pkg::pow_tab(k + 1);

            if (k == 0)
            begin : g_first
                assign exp_in[k]     = y_reg;
                assign exp_vld_in[k] = y_vld_reg;
            end
            else
            begin : g_rest
                assign exp_in[k]     = exp_reg[k-1];
                assign exp_vld_in[k] = exp_vld_reg[k-1];
            end

            always_comb
            begin
                logic [64:0] prod;
                exp_next[k] = exp_in[k];
                for (int i = 0; i < 2; i++)
                begin
                    prod = 65'(exp_in[k].e[i]) * 65'(CK);
                    if (exp_in[k].frac[i][15-k])
                    begin
                        exp_next[k].e[i] = prod[64:32];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    exp_vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    exp_vld_reg[k] <= exp_vld_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    exp_reg[k] <= exp_next[k];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Integer part of the exponent as a right shift
    work_t sh_reg, sh_next;
    logic  sh_vld_reg;

    always_comb
    begin
        sh_next = exp_reg[EXP_STAGES-1];
        for (int i = 0; i < 2; i++)
        begin
            sh_next.e[i] = exp_reg[EXP_STAGES-1].zero[i] ? 33'd0 :
                           (exp_reg[EXP_STAGES-1].e[i] >> exp_reg[EXP_STAGES-1].nsh[i]);
        end
    end

    // ------------------------------------------------------------------
    // q = exp * dt
    work_t q_reg, q_next;
    logic  q_vld_reg;

    always_comb
    begin
        logic [64:0] qp;
        q_next = sh_reg;
        for (int i = 0; i < 2; i++)
        begin
            qp          = 65'(sh_reg.e[i]) * 65'(sh_reg.dt);
            q_next.q[i] = qp[63:0];
        end
    end

    // ------------------------------------------------------------------
    // q * raw, two 32x32 partial products
    work_t p1_reg, p1_next;
    logic  p1_vld_reg;

    always_comb
    begin
        p1_next = q_reg;
        for (int i = 0; i < 2; i++)
        begin
            p1_next.pl[i] = 64'(q_reg.q[i][31:0]) * 64'(q_reg.raw);
            p1_next.ph[i] = 64'(q_reg.q[i][63:32]) * 64'(q_reg.raw);
        end
    end

    // ------------------------------------------------------------------
    // v = (q * raw) >> 32
    work_t v_reg, v_next;
    logic  v_vld_reg;

    always_comb
    begin
        logic [64:0] vs;
        v_next = p1_reg;
        for (int i = 0; i < 2; i++)
        begin
            vs          = 65'(p1_reg.ph[i]) + 65'(p1_reg.pl[i][63:32]);
            v_next.v[i] = vs[63:0];
        end
    end

    // ------------------------------------------------------------------
    // v * A, four partial products
    work_t p2_reg, p2_next;
    logic  p2_vld_reg;

    always_comb
    begin
        p2_next = v_reg;
        for (int i = 0; i < 2; i++)
        begin
            p2_next.p00[i] = 64'(v_reg.v[i][31:0]) * 64'(rate_w[i][31:0]);
            p2_next.p01[i] = 48'(v_reg.v[i][31:0]) * 48'(rate_w[i][47:32]);
            p2_next.p10[i] = 64'(v_reg.v[i][63:32]) * 64'(rate_w[i][31:0]);
            p2_next.p11[i] = 48'(v_reg.v[i][63:32]) * 48'(rate_w[i][47:32]);
        end
    end

    // ------------------------------------------------------------------
    // dm = (v * A) >> 32, clamped; disabled reactions give nothing
    work_t dm_reg, dm_next;
    logic  dm_vld_reg;

    always_comb
    begin
        logic [80:0] s;
        dm_next = p2_reg;
        for (int i = 0; i < 2; i++)
        begin
            s = 81'(p2_reg.p00[i][63:32]) + 81'(p2_reg.p01[i]) + 81'(p2_reg.p10[i])
              + 81'({p2_reg.p11[i], 32'd0});
            if (!p2_reg.en[i])
            begin
                dm_next.dm[i] = 32'd0;
            end
            else if (s > 81'(tsad_pkg::DM_MAX))
            begin
                dm_next.dm[i] = tsad_pkg::DM_MAX;
            end
            else
            begin
                dm_next.dm[i] = s[31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Gas share by yield
    work_t g_reg, g_next;
    logic  g_vld_reg;

    always_comb
    begin
        logic [47:0] gp;
        g_next = dm_reg;
        for (int i = 0; i < 2; i++)
        begin
            gp          = 48'(dm_reg.dm[i]) * 48'(yield_w[i]);
            g_next.g[i] = gp[47:16];
        end
    end

    // ------------------------------------------------------------------
    // Output register: sums and signs
    logic signed [33:0] gas_first_reg, gas_first_next;
    logic signed [32:0] gas_second_reg, gas_second_next;
    logic signed [33:0] char_reg, char_next;
    logic [32:0]        raw_reg, raw_next;

    always_comb
    begin
        logic [31:0] c0;
        logic [31:0] c1;
        logic [32:0] gsum;
        c0 = g_reg.dm[0] - g_reg.g[0];
        c1 = g_reg.dm[1] - g_reg.g[1];
        if (tsad_pkg::SINGLE_SPECIES)
        begin
            gsum            = 33'(g_reg.g[0]) + 33'(g_reg.g[1]);
            gas_second_next = '0;
        end
        else
        begin
            gsum            = 33'(g_reg.g[0]);
            gas_second_next = -$signed(33'(g_reg.g[1]));
        end
        gas_first_next = -$signed(34'(gsum));
        char_next      = -$signed(34'(c0) + 34'(c1));
        raw_next       = 33'(g_reg.dm[0]) + 33'(g_reg.dm[1]);
    end

    // ------------------------------------------------------------------
    // Valid bits for the named stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            y_vld_reg   <= 1'b0;
            sh_vld_reg  <= 1'b0;
            q_vld_reg   <= 1'b0;
            p1_vld_reg  <= 1'b0;
            v_vld_reg   <= 1'b0;
            p2_vld_reg  <= 1'b0;
            dm_vld_reg  <= 1'b0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg  <= in_valid;
            y_vld_reg   <= div_vld_reg[DIV_STAGES-1];
            sh_vld_reg  <= exp_vld_reg[EXP_STAGES-1];
            q_vld_reg   <= sh_vld_reg;
            p1_vld_reg  <= q_vld_reg;
            v_vld_reg   <= p1_vld_reg;
            p2_vld_reg  <= v_vld_reg;
            dm_vld_reg  <= p2_vld_reg;
            g_vld_reg   <= dm_vld_reg;
            out_vld_reg <= g_vld_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg         <= in_next;
            y_reg          <= y_next;
            sh_reg         <= sh_next;
            q_reg          <= q_next;
            p1_reg         <= p1_next;
            v_reg          <= v_next;
            p2_reg         <= p2_next;
            dm_reg         <= dm_next;
            g_reg          <= g_next;
            gas_first_reg  <= gas_first_next;
            gas_second_reg <= gas_second_next;
            char_reg       <= char_next;
            raw_reg        <= raw_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign gas_delta_first  = gas_first_reg;
    assign gas_delta_second = gas_second_reg;
    assign char_delta       = char_reg;
    assign raw_delta        = raw_reg;

    // ------------------------------------------------------------------
    // Checks

    // mass balance: gas and char losses add up to the raw gain
    a_mass_balance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (35'({gas_delta_first[33], gas_delta_first})
                     + 35'({{2{gas_delta_second[32]}}, gas_delta_second})
                     + 35'({char_delta[33], char_delta})
                     + 35'({2'b00, raw_delta})) == 35'd0)
        else $error("gas, char and raw increments do not balance");

    // back-pressure only comes from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // first gas increment never positive
    a_gas_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gas_delta_first[33] || gas_delta_first == 34'sd0))
        else $error("positive gas increment");

endmodule

`default_nettype wire
